// ===== hw/rtl/snnc_pkg.sv =====
// Shared types and codes for the shared-neighbour counter.
`default_nettype none

package snnc_pkg;

  // Field widths fixed by the item format
  localparam int NODE_W   = 6;
  localparam int COUNT_W  = 6;
  localparam int CFG_W    = 7;

  // Opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Node count after reset
  localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic              opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } snnc_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] common_count;
    logic               linked;
    logic               valid_res;
  } snnc_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/snnc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module snnc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/snn_common_neighbour_counter.sv =====
// Top level: adjacency matrix store and shared-neighbour counting sequencer.
`default_nettype none

// Keeps the adjacency matrix of an undirected graph, one RAM row per node, and
// takes one item at a time. An add item links node_a and node_b; a query item
// reports whether the pair is linked and, if so, how many neighbours below the
// node count the two share. Every item gives exactly one result. in_ready is
// high only while the sequencer is idle. An item with a bad pair (equal
// indices, or an index not below min(node_count, MAX_NODES)) skips the RAM;
// an add does two row reads and two row writes through the RAM; a query reads
// both rows, and for a linked pair the common row is counted 8 bits per cycle
// by one popcount unit. A result waiting at the output holds the sequencer in
// its last step until taken. Rows start cleared after reset by per-row valid
// flags, so no clearing pass is needed. node_count is written through
// cfg_wr_en / cfg_wr_data; the user must write it only while the block is
// idle, as the block itself does not enforce this.
module snn_common_neighbour_counter
  import snnc_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire snnc_in_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output snnc_out_t             out_data
);

  localparam int AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LW_MIN = $clog2(MAX_NODES + 1);
  localparam int LW     = (LW_MIN > CFG_W) ? LW_MIN : CFG_W;
  localparam int CHUNK  = 8;
  localparam int NCHUNK = (MAX_NODES + CHUNK - 1) / CHUNK;
  localparam int PADW   = NCHUNK * CHUNK;
  localparam int CCW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int CW     = $clog2(MAX_NODES + 1);
  localparam int PCW    = $clog2(CHUNK + 1);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_RD_A    = 8'b0000_0010,
    ST_RD_B    = 8'b0000_0100,
    ST_LATCH_B = 8'b0000_1000,
    ST_WR_A    = 8'b0001_0000,
    ST_WR_B    = 8'b0010_0000,
    ST_COUNT   = 8'b0100_0000,
    ST_RESULT  = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0]     node_count;
  logic [LW-1:0]        limit;
  logic [MAX_NODES-1:0] row_valid;
  logic                 rvalid;

  logic                 op;
  logic [AW-1:0]        a_idx;
  logic [AW-1:0]        b_idx;
  logic [MAX_NODES-1:0] row_a;
  logic [MAX_NODES-1:0] row_b;
  logic [PADW-1:0]      and_vec;
  logic [CCW-1:0]       chunk;
  logic [CW-1:0]        count;
  logic                 res_linked;
  logic                 res_valid;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [MAX_NODES-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [MAX_NODES-1:0] ram_rdata;
  logic [MAX_NODES-1:0] rd_row;
  logic [PADW-1:0]      limit_mask;
  logic                 pair_ok;
  logic                 accept;
  logic                 out_free;

  // Popcount of one chunk
  function automatic logic [PCW-1:0] popcount(input logic [CHUNK-1:0] v);
    logic [PCW-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK; i++) begin
      n = n + PCW'(v[i]);
    end
    return n;
  endfunction

  // Active limit saturates at MAX_NODES
  assign limit = (LW'(node_count) > LW'(MAX_NODES)) ? LW'(MAX_NODES) : LW'(node_count);

  // Columns below the limit
  always_comb begin
    for (int i = 0; i < PADW; i++) begin
      limit_mask[i] = (LW'(i) < limit);
    end
  end

  // Pair check on the incoming item
  assign pair_ok = (in_data.node_a != in_data.node_b)
                && (LW'(in_data.node_a) < limit)
                && (LW'(in_data.node_b) < limit);

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Row read masked by its valid flag
  assign rd_row = rvalid ? ram_rdata : '0;

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_idx;
    ram_wdata = row_a | (MAX_NODES'(1) << b_idx);
    ram_raddr = a_idx;
    case (state)
      ST_RD_B: begin
        ram_raddr = b_idx;
      end
      ST_WR_A: begin
        ram_we = 1'b1;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = b_idx;
        ram_wdata = row_b | (MAX_NODES'(1) << a_idx);
      end
      default: begin
      end
    endcase
  end

  snnc_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = pair_ok ? ST_RD_A : ST_RESULT;
        end
      end
      ST_RD_A:  state_next = ST_RD_B;
      ST_RD_B:  state_next = ST_LATCH_B;
      ST_LATCH_B: begin
        if (op == OP_ADD) begin
          state_next = ST_WR_A;
        end else if (row_a[b_idx]) begin
          state_next = ST_COUNT;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_WR_A:  state_next = ST_WR_B;
      ST_WR_B:  state_next = ST_RESULT;
      ST_COUNT: begin
        if (chunk == CCW'(NCHUNK - 1)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= NODE_COUNT_RESET;
      row_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rvalid <= row_valid[ram_raddr];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op         <= in_data.opcode;
          a_idx      <= AW'(in_data.node_a);
          b_idx      <= AW'(in_data.node_b);
          count      <= '0;
          chunk      <= '0;
          res_linked <= 1'b0;
          res_valid  <= pair_ok;
        end
      end
      ST_RD_B: begin
        row_a <= rd_row;
      end
      ST_LATCH_B: begin
        row_b      <= rd_row;
        and_vec    <= PADW'(row_a & rd_row) & limit_mask;
        res_linked <= (op == OP_ADD) || row_a[b_idx];
      end
      ST_COUNT: begin
        count   <= count + CW'(popcount(and_vec[CHUNK-1:0]));
        and_vec <= and_vec >> CHUNK;
        chunk   <= chunk + CCW'(1);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_data.common_count <= COUNT_W'(count);
          out_data.linked       <= res_linked;
          out_data.valid_res    <= res_valid;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the shared-neighbour counter: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps

module tb;
  import snnc_pkg::*;

  localparam int NODES         = 64;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 300;
  localparam int STALL_LIMIT   = 2000;

  // Mirror of the adjacency matrix plus the queue of results still owed by the block
  class neighbour_scoreboard;
    logic [NODES-1:0] adj [NODES];
    logic [CFG_W-1:0] node_count;
    snnc_out_t        owed [$];
    int               errors;

    function new();
      foreach (adj[i]) adj[i] = '0;
      node_count = NODE_COUNT_RESET;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Work out the result of one accepted item and update the matrix
    function void note_item(input snnc_in_t it);
      snnc_out_t        want;
      int               lim;
      logic [NODES-1:0] mask;
      lim = (node_count > NODES) ? NODES : int'(node_count);
      want = '0;
      if (it.node_a != it.node_b && it.node_a < lim && it.node_b < lim) begin
        want.valid_res = 1'b1;
        if (it.opcode == OP_ADD) begin
          adj[it.node_a][it.node_b] = 1'b1;
          adj[it.node_b][it.node_a] = 1'b1;
          want.linked = 1'b1;
        end else if (adj[it.node_a][it.node_b]) begin
          // only neighbours below the current limit count
          mask = ~({NODES{1'b1}} << lim);
          want.linked = 1'b1;
          want.common_count = COUNT_W'($countones(adj[it.node_a] & adj[it.node_b] & mask));
        end
      end
      owed.push_back(want);
    endfunction

    task check_result(input snnc_out_t got);
      snnc_out_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result count %0d linked %0b valid %0b",
                         got.common_count, got.linked, got.valid_res));
        return;
      end
      want = owed.pop_front();
      if (got.common_count !== want.common_count)
        report($sformatf("common_count got %0d want %0d", got.common_count, want.common_count));
      if (got.linked !== want.linked)
        report($sformatf("linked got %0b want %0b", got.linked, want.linked));
      if (got.valid_res !== want.valid_res)
        report($sformatf("valid_res got %0b want %0b", got.valid_res, want.valid_res));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  snnc_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  snnc_out_t        out_data;

  neighbour_scoreboard sb;
  bit                  tx_idle = 1'b0;
  bit                  rx_idle = 1'b0;
  bit                  hold_request = 1'b0;
  int                  quiet_cycles = 0;
  logic [NODE_W-1:0]   added_a [$];
  logic [NODE_W-1:0]   added_b [$];

  snn_common_neighbour_counter #(.MAX_NODES(NODES)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic int pick_gap(input bit enabled);
    if (!enabled || $urandom_range(0, 99) < 55) return 0;
    return gap_len();
  endfunction

  // Offer one item, hold it until the block takes it
  task automatic send_item(input snnc_in_t it);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_op(input logic op, input int a, input int b);
    snnc_in_t it;
    it.opcode = op;
    it.node_a = NODE_W'(a);
    it.node_b = NODE_W'(b);
    send_item(it);
  endtask

  // Drain, let the sequencer settle, then write node_count
  task automatic write_node_count(input int value);
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.node_count = CFG_W'(value);
  endtask

  // Random items, mostly over nodes below span; hub mode grows two dense rows
  task automatic run_random(input int n, input int span, input bit hub_mode);
    snnc_in_t it;
    int       k, r, ia, ib, hub_a, hub_b, pick;
    hub_a = $urandom_range(0, span - 1);
    hub_b = (hub_a + $urandom_range(1, span - 1)) % span;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      it.opcode = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_QUERY;
      if (r < 10) begin
        // noise: any index pair, often invalid
        ia = $urandom_range(0, NODES - 1);
        ib = (r < 3) ? ia : $urandom_range(0, NODES - 1);
      end else if (hub_mode && it.opcode == OP_ADD) begin
        ia = (r < 55) ? hub_a : hub_b;
        ib = $urandom_range(0, span - 1);
      end else if (hub_mode && r < 60) begin
        it.opcode = OP_QUERY;
        ia = hub_a;
        ib = hub_b;
      end else if (it.opcode == OP_QUERY && added_a.size() > 0 && r < 60) begin
        pick = $urandom_range(0, added_a.size() - 1);
        ia = added_a[pick];
        ib = added_b[pick];
      end else begin
        ia = $urandom_range(0, span - 1);
        ib = (ia + $urandom_range(1, span - 1)) % span;
      end
      if ($urandom_range(0, 1) == 1) begin
        pick = ia;
        ia = ib;
        ib = pick;
      end
      it.node_a = NODE_W'(ia);
      it.node_b = NODE_W'(ib);
      if (it.opcode == OP_ADD) begin
        added_a.push_back(it.node_a);
        added_b.push_back(it.node_b);
      end
      send_item(it);
    end
  endtask

  // Result check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: runs of ready and stalls, plus one long hold on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!rx_idle || $urandom_range(0, 99) >= 30) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  // Stimulus
  initial begin
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, duplicates, bad pairs, small shared counts
    send_op(OP_QUERY, 0, 63);
    send_op(OP_ADD, 0, 63);
    send_op(OP_ADD, 63, 0);
    send_op(OP_QUERY, 63, 0);
    send_op(OP_ADD, 5, 5);
    send_op(OP_QUERY, 63, 63);
    send_op(OP_ADD, 0, 1);
    send_op(OP_ADD, 1, 63);
    send_op(OP_ADD, 62, 63);
    send_op(OP_ADD, 0, 62);
    send_op(OP_QUERY, 0, 63);
    send_op(OP_ADD, 42, 21);
    send_op(OP_QUERY, 21, 42);
    // count above the node limit saturates
    write_node_count(127);
    send_op(OP_QUERY, 63, 0);
    // lowered count: stored bits stay, only low neighbours count
    write_node_count(10);
    send_op(OP_QUERY, 0, 63);
    send_op(OP_ADD, 0, 9);
    send_op(OP_ADD, 1, 9);
    send_op(OP_QUERY, 0, 1);
    write_node_count(2);
    send_op(OP_ADD, 0, 1);
    send_op(OP_ADD, 0, 2);
    send_op(OP_QUERY, 1, 0);
    // fewer than two nodes: nothing is valid
    write_node_count(0);
    send_op(OP_ADD, 0, 1);
    write_node_count(1);
    send_op(OP_QUERY, 1, 0);

    // Random phases
    write_node_count(64);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    run_random(250, 64, 1'b0);

    write_node_count(16);
    rx_idle = 1'b0;
    run_random(200, 16, 1'b0);

    // Long receiver hold while the sender keeps offering
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_request = 1'b1;
    run_random(60, 16, 1'b0);

    write_node_count(64);
    rx_idle = 1'b0;
    run_random(200, 64, 1'b1);

    write_node_count(127);
    rx_idle = 1'b1;
    run_random(150, 64, 1'b0);

    write_node_count(33);
    tx_idle = 1'b1;
    run_random(150, 33, 1'b1);

    write_node_count(2);
    run_random(50, 2, 1'b0);

    write_node_count(100);
    run_random(200, 64, 1'b1);

    // Drain and finish
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== snn_common_neighbour_counter.f =====
hw/rtl/snnc_pkg.sv
hw/rtl/snnc_ram.sv
hw/rtl/snn_common_neighbour_counter.sv
tb/tb.sv
